/* src/cfa_pkg.sv */
package cfa_pkg;

    localparam int DEF_MAX_BLOCKS = 16;
    localparam int ADDR_BITS      = 16;
    localparam int OWNER_BITS     = 8;
    localparam int HOLES_BITS     = 5;
    localparam logic [ADDR_BITS-1:0] RESET_TOTAL = 16'd1024;

    typedef enum logic [1:0] {
        ACT_REQUEST,
        ACT_RELEASE,
        ACT_COMPACT,
        ACT_REPORT
    } t_action;

    typedef enum logic [1:0] {
        STRAT_FIRST,
        STRAT_BEST,
        STRAT_WORST,
        STRAT_INVALID
    } t_strategy;

    typedef enum logic [2:0] {
        ST_OK,
        ST_BAD_SIZE,
        ST_DUPLICATE,
        ST_BAD_STRATEGY,
        ST_NO_FIT,
        ST_NOT_FOUND,
        ST_TABLE_FULL
    } t_status;

    typedef struct packed {
        t_action                 action;
        logic [OWNER_BITS-1:0]   process_id;
        logic [ADDR_BITS-1:0]    request_size;
        t_strategy               strategy;
    } t_in_word;

    typedef struct packed {
        t_status                 status;
        logic [ADDR_BITS-1:0]    block_start;
        logic [ADDR_BITS-1:0]    total_allocated;
        logic [ADDR_BITS-1:0]    total_free;
        logic [ADDR_BITS-1:0]    largest_hole;
        logic [HOLES_BITS-1:0]   holes_present;
    } t_out_word;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_CFG,
        OP_LOAD,
        OP_SETST,
        OP_BSCAN,
        OP_HSCAN,
        OP_CARVE,
        OP_RTAKE,
        OP_PSCAN,
        OP_MERGE,
        OP_CPASS,
        OP_CPLACE,
        OP_CFILL,
        OP_LSCAN,
        OP_EMIT
    } t_op;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_BSCAN,
        S_CHECK,
        S_HSCAN,
        S_HDEC,
        S_CARVE,
        S_RTAKE,
        S_PSCAN,
        S_MERGE,
        S_CPASS,
        S_CDEC,
        S_CPLACE,
        S_CFILL,
        S_LSCAN,
        S_OUT
    } t_state;

    typedef struct packed {
        t_op     op;
        t_status code;
    } t_cmd;

    typedef struct packed {
        t_action action;
        logic    size_zero;
        logic    strat_bad;
        logic    found;
        logic    slot_ok;
        logic    chosen_ok;
        logic    best_ok;
        logic    b_last;
        logic    h_last;
        logic    out_busy;
    } t_dp_stat;

endpackage

/* src/cfa_dp.sv */
module cfa_dp #(
    parameter int MAX_BLOCKS = cfa_pkg::DEF_MAX_BLOCKS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  cfa_pkg::t_cmd                      i_cmd,
    input  cfa_pkg::t_in_word                  i_in_word,
    input  logic [cfa_pkg::ADDR_BITS-1:0]      i_cfg_data,
    input  logic                               i_out_stall,
    output cfa_pkg::t_dp_stat                  o_stat,
    output logic                               o_out_valid,
    output cfa_pkg::t_out_word                 o_out_word
);

    localparam int HD = MAX_BLOCKS + 1;
    localparam int IW = $clog2(HD);
    localparam int BW = $clog2(MAX_BLOCKS);
    localparam int CW = $clog2(HD + 1);
    localparam int AW = cfa_pkg::ADDR_BITS;
    localparam int OW = cfa_pkg::OWNER_BITS;

    logic [MAX_BLOCKS-1:0]  r_bval;
    logic [OW-1:0]          r_bown  [MAX_BLOCKS];
    logic [AW-1:0]          r_bbase [MAX_BLOCKS];
    logic [AW-1:0]          r_blen  [MAX_BLOCKS];
    logic [AW-1:0]          r_hbase [HD];
    logic [AW-1:0]          r_hlen  [HD];
    logic [CW-1:0]          r_hused;
    logic [AW-1:0]          r_total;
    logic [AW-1:0]          r_alloc;
    logic [IW-1:0]          r_idx;
    cfa_pkg::t_in_word      r_item;
    cfa_pkg::t_status       r_status;
    logic [AW-1:0]          r_start;
    logic                   r_found;
    logic [BW-1:0]          r_fidx;
    logic [AW-1:0]          r_fbase;
    logic [AW-1:0]          r_flen;
    logic                   r_slot_ok;
    logic [BW-1:0]          r_slot;
    logic                   r_chosen_ok;
    logic [IW-1:0]          r_chosen;
    logic [AW-1:0]          r_pick;
    logic [AW-1:0]          r_cbase;
    logic                   r_prev_ok;
    logic [AW-1:0]          r_pbase;
    logic [AW-1:0]          r_plen;
    logic                   r_next_ok;
    logic [AW-1:0]          r_nbase;
    logic [AW-1:0]          r_nlen;
    logic [IW-1:0]          r_pos;
    logic [MAX_BLOCKS-1:0]  r_done;
    logic                   r_best_ok;
    logic [BW-1:0]          r_best;
    logic [AW-1:0]          r_best_base;
    logic [AW-1:0]          r_best_len;
    logic [AW:0]            r_offset;
    logic [AW-1:0]          r_largest;
    logic                   r_ovalid;
    cfa_pkg::t_out_word     r_out;

    logic [BW-1:0] bidx;
    logic          b_last;
    logic          h_last;
    logic          h_in;
    logic          cur_bval;
    logic [OW-1:0] cur_bown;
    logic [AW-1:0] cur_bbase;
    logic [AW-1:0] cur_blen;
    logic [AW-1:0] cur_hbase;
    logic [AW-1:0] cur_hlen;
    logic          owner_hit;
    logic          take_hole;
    logic [AW-1:0] prev_end;
    logic [AW-1:0] grown;
    logic          join_prev;
    logic          join_both;
    logic          join_next;
    logic [IW-1:0] pos_m1;
    logic [AW:0]   total_ext;

    assign bidx      = r_idx[BW-1:0];
    assign b_last    = (r_idx == IW'(MAX_BLOCKS - 1));
    assign h_last    = (r_idx == IW'(HD - 1));
    assign h_in      = (CW'(r_idx) < r_hused);
    assign cur_bval  = r_bval[bidx];
    assign cur_bown  = r_bown[bidx];
    assign cur_bbase = r_bbase[bidx];
    assign cur_blen  = r_blen[bidx];
    assign cur_hbase = r_hbase[r_idx];
    assign cur_hlen  = r_hlen[r_idx];
    assign owner_hit = cur_bval && (cur_bown == r_item.process_id);

    always_comb begin
        take_hole = 1'b0;
        if (h_in && (cur_hlen >= r_item.request_size)) begin
            unique case (r_item.strategy)
                cfa_pkg::STRAT_FIRST: take_hole = !r_chosen_ok;
                cfa_pkg::STRAT_BEST:  take_hole = !r_chosen_ok || (cur_hlen < r_pick);
                cfa_pkg::STRAT_WORST: take_hole = !r_chosen_ok || (cur_hlen > r_pick);
                default:              take_hole = 1'b0;
            endcase
        end
    end

    // Neighbors of the released block, captured during the position scan.
    assign prev_end  = r_pbase + r_plen;
    assign grown     = r_plen + r_flen;
    assign join_prev = r_prev_ok && (prev_end == r_fbase);
    assign join_both = join_prev && r_next_ok && ((r_pbase + grown) == r_nbase);
    assign join_next = !join_prev && r_next_ok && ((r_fbase + r_flen) == r_nbase);
    assign pos_m1    = r_pos - IW'(1);
    assign total_ext = {1'b0, r_total};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bval     <= '0;
            r_hused    <= CW'(1);
            r_total    <= cfa_pkg::RESET_TOTAL;
            r_alloc    <= '0;
            r_idx      <= '0;
            r_ovalid   <= 1'b0;
            r_hbase[0] <= '0;
            r_hlen[0]  <= cfa_pkg::RESET_TOTAL;
        end else begin
            if (r_ovalid && !i_out_stall) begin
                r_ovalid <= 1'b0;
            end
            unique case (i_cmd.op)
                cfa_pkg::OP_CFG: begin
                    r_total <= i_cfg_data;
                    r_bval  <= '0;
                    r_alloc <= '0;
                    for (int k = 0; k < HD; k++) begin
                        r_hbase[k] <= '0;
                        r_hlen[k]  <= '0;
                    end
                    if (i_cfg_data != '0) begin
                        r_hlen[0] <= i_cfg_data;
                        r_hused   <= CW'(1);
                    end else begin
                        r_hused   <= '0;
                    end
                end
                cfa_pkg::OP_LOAD: begin
                    r_item      <= i_in_word;
                    r_status    <= cfa_pkg::ST_OK;
                    r_start     <= '0;
                    r_found     <= 1'b0;
                    r_slot_ok   <= 1'b0;
                    r_chosen_ok <= 1'b0;
                    r_best_ok   <= 1'b0;
                    r_largest   <= '0;
                    r_offset    <= '0;
                    r_done      <= '0;
                    r_idx       <= '0;
                end
                cfa_pkg::OP_SETST: begin
                    r_status <= i_cmd.code;
                end
                cfa_pkg::OP_BSCAN: begin
                    if (owner_hit && !r_found) begin
                        r_found <= 1'b1;
                        r_fidx  <= bidx;
                        r_fbase <= cur_bbase;
                        r_flen  <= cur_blen;
                    end
                    if (!cur_bval && !r_slot_ok) begin
                        r_slot_ok <= 1'b1;
                        r_slot    <= bidx;
                    end
                    r_idx <= b_last ? '0 : r_idx + IW'(1);
                end
                cfa_pkg::OP_HSCAN: begin
                    if (take_hole) begin
                        r_chosen_ok <= 1'b1;
                        r_chosen    <= r_idx;
                        r_pick      <= cur_hlen;
                        r_cbase     <= cur_hbase;
                    end
                    r_idx <= h_last ? '0 : r_idx + IW'(1);
                end
                cfa_pkg::OP_CARVE: begin
                    r_bval[r_slot]  <= 1'b1;
                    r_bown[r_slot]  <= r_item.process_id;
                    r_bbase[r_slot] <= r_cbase;
                    r_blen[r_slot]  <= r_item.request_size;
                    r_alloc         <= r_alloc + r_item.request_size;
                    r_start         <= r_cbase;
                    if (r_pick == r_item.request_size) begin
                        // The hole is used up: close the gap in the sorted table.
                        for (int k = 0; k < HD - 1; k++) begin
                            if (IW'(k) >= r_chosen) begin
                                r_hbase[k] <= r_hbase[k+1];
                                r_hlen[k]  <= r_hlen[k+1];
                            end
                        end
                        r_hbase[HD-1] <= '0;
                        r_hlen[HD-1]  <= '0;
                        r_hused       <= r_hused - CW'(1);
                    end else begin
                        r_hbase[r_chosen] <= r_cbase + r_item.request_size;
                        r_hlen[r_chosen]  <= r_pick - r_item.request_size;
                    end
                end
                cfa_pkg::OP_RTAKE: begin
                    r_bval[r_fidx] <= 1'b0;
                    r_alloc        <= r_alloc - r_flen;
                    r_start        <= r_fbase;
                    r_prev_ok      <= 1'b0;
                    r_next_ok      <= 1'b0;
                    r_pos          <= '0;
                end
                cfa_pkg::OP_PSCAN: begin
                    if (h_in) begin
                        if (cur_hbase < r_fbase) begin
                            r_prev_ok <= 1'b1;
                            r_pbase   <= cur_hbase;
                            r_plen    <= cur_hlen;
                            r_pos     <= r_idx + IW'(1);
                        end else if (!r_next_ok) begin
                            r_next_ok <= 1'b1;
                            r_nbase   <= cur_hbase;
                            r_nlen    <= cur_hlen;
                        end
                    end
                    r_idx <= h_last ? '0 : r_idx + IW'(1);
                end
                cfa_pkg::OP_MERGE: begin
                    if (join_both) begin
                        r_hlen[pos_m1] <= grown + r_nlen;
                        for (int k = 0; k < HD - 1; k++) begin
                            if (IW'(k) >= r_pos) begin
                                r_hbase[k] <= r_hbase[k+1];
                                r_hlen[k]  <= r_hlen[k+1];
                            end
                        end
                        r_hbase[HD-1] <= '0;
                        r_hlen[HD-1]  <= '0;
                        r_hused       <= r_hused - CW'(1);
                    end else if (join_prev) begin
                        r_hlen[pos_m1] <= grown;
                    end else if (join_next) begin
                        r_hbase[r_pos] <= r_fbase;
                        r_hlen[r_pos]  <= r_nlen + r_flen;
                    end else begin
                        for (int k = 1; k < HD; k++) begin
                            if (IW'(k) > r_pos) begin
                                r_hbase[k] <= r_hbase[k-1];
                                r_hlen[k]  <= r_hlen[k-1];
                            end
                        end
                        r_hbase[r_pos] <= r_fbase;
                        r_hlen[r_pos]  <= r_flen;
                        r_hused        <= r_hused + CW'(1);
                    end
                end
                cfa_pkg::OP_CPASS: begin
                    if (cur_bval && !r_done[bidx] &&
                        (!r_best_ok || (cur_bbase < r_best_base))) begin
                        r_best_ok   <= 1'b1;
                        r_best      <= bidx;
                        r_best_base <= cur_bbase;
                        r_best_len  <= cur_blen;
                    end
                    r_idx <= b_last ? '0 : r_idx + IW'(1);
                end
                cfa_pkg::OP_CPLACE: begin
                    r_bbase[r_best] <= r_offset[AW-1:0];
                    r_done[r_best]  <= 1'b1;
                    r_offset        <= r_offset + {1'b0, r_best_len};
                    r_best_ok       <= 1'b0;
                end
                cfa_pkg::OP_CFILL: begin
                    for (int k = 0; k < HD; k++) begin
                        r_hbase[k] <= '0;
                        r_hlen[k]  <= '0;
                    end
                    if (total_ext > r_offset) begin
                        r_hbase[0] <= r_offset[AW-1:0];
                        r_hlen[0]  <= AW'(total_ext - r_offset);
                        r_hused    <= CW'(1);
                    end else begin
                        r_hused    <= '0;
                    end
                end
                cfa_pkg::OP_LSCAN: begin
                    if (h_in && (cur_hlen > r_largest)) begin
                        r_largest <= cur_hlen;
                    end
                    r_idx <= h_last ? '0 : r_idx + IW'(1);
                end
                cfa_pkg::OP_EMIT: begin
                    r_out.status          <= r_status;
                    r_out.block_start     <= r_start;
                    r_out.total_allocated <= r_alloc;
                    r_out.total_free      <= r_total - r_alloc;
                    r_out.largest_hole    <= r_largest;
                    r_out.holes_present   <= cfa_pkg::HOLES_BITS'(r_hused);
                    r_ovalid              <= 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    assign o_stat.action    = r_item.action;
    assign o_stat.size_zero = (r_item.request_size == '0);
    assign o_stat.strat_bad = (r_item.strategy == cfa_pkg::STRAT_INVALID);
    assign o_stat.found     = r_found;
    assign o_stat.slot_ok   = r_slot_ok;
    assign o_stat.chosen_ok = r_chosen_ok;
    assign o_stat.best_ok   = r_best_ok;
    assign o_stat.b_last    = b_last;
    assign o_stat.h_last    = h_last;
    assign o_stat.out_busy  = r_ovalid && i_out_stall;

    assign o_out_valid = r_ovalid;
    assign o_out_word  = r_out;

`ifndef NO_ASSERTIONS
    a_hused_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hused <= CW'(HD))
        else $error("hole count exceeds the table depth");

    a_alloc_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_alloc <= r_total)
        else $error("allocated total exceeds managed memory");

    a_emit_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.op == cfa_pkg::OP_EMIT |=> r_ovalid)
        else $error("emitted word not held in the output register");
`endif

endmodule

/* src/cfa_ctrl.sv */
module cfa_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_cfg_valid,
    input  cfa_pkg::t_dp_stat  i_stat,
    output cfa_pkg::t_cmd      o_cmd,
    output logic               o_in_stall,
    output logic               o_cfg_ready
);

    cfa_pkg::t_state r_state;
    cfa_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cfa_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd.op    = cfa_pkg::OP_NONE;
        o_cmd.code  = cfa_pkg::ST_OK;
        o_cfg_ready = 1'b0;
        o_in_stall  = 1'b1;
        unique case (r_state)
            cfa_pkg::S_IDLE: begin
                o_cfg_ready = 1'b1;
                o_in_stall  = i_cfg_valid;
                if (i_cfg_valid) begin
                    o_cmd.op = cfa_pkg::OP_CFG;
                end else if (i_in_valid) begin
                    o_cmd.op = cfa_pkg::OP_LOAD;
                    n_state  = cfa_pkg::S_DISPATCH;
                end
            end
            cfa_pkg::S_DISPATCH: begin
                unique case (i_stat.action)
                    cfa_pkg::ACT_REQUEST: begin
                        if (i_stat.size_zero) begin
                            o_cmd.op   = cfa_pkg::OP_SETST;
                            o_cmd.code = cfa_pkg::ST_BAD_SIZE;
                            n_state    = cfa_pkg::S_LSCAN;
                        end else begin
                            n_state = cfa_pkg::S_BSCAN;
                        end
                    end
                    cfa_pkg::ACT_RELEASE: n_state = cfa_pkg::S_BSCAN;
                    cfa_pkg::ACT_COMPACT: n_state = cfa_pkg::S_CPASS;
                    default:              n_state = cfa_pkg::S_LSCAN;
                endcase
            end
            cfa_pkg::S_BSCAN: begin
                o_cmd.op = cfa_pkg::OP_BSCAN;
                if (i_stat.b_last) begin
                    n_state = cfa_pkg::S_CHECK;
                end
            end
            cfa_pkg::S_CHECK: begin
                n_state = cfa_pkg::S_LSCAN;
                if (i_stat.action == cfa_pkg::ACT_RELEASE) begin
                    if (i_stat.found) begin
                        n_state = cfa_pkg::S_RTAKE;
                    end else begin
                        o_cmd.op   = cfa_pkg::OP_SETST;
                        o_cmd.code = cfa_pkg::ST_NOT_FOUND;
                    end
                end else begin
                    priority if (i_stat.found) begin
                        o_cmd.op   = cfa_pkg::OP_SETST;
                        o_cmd.code = cfa_pkg::ST_DUPLICATE;
                    end else if (i_stat.strat_bad) begin
                        o_cmd.op   = cfa_pkg::OP_SETST;
                        o_cmd.code = cfa_pkg::ST_BAD_STRATEGY;
                    end else if (!i_stat.slot_ok) begin
                        o_cmd.op   = cfa_pkg::OP_SETST;
                        o_cmd.code = cfa_pkg::ST_TABLE_FULL;
                    end else begin
                        n_state = cfa_pkg::S_HSCAN;
                    end
                end
            end
            cfa_pkg::S_HSCAN: begin
                o_cmd.op = cfa_pkg::OP_HSCAN;
                if (i_stat.h_last) begin
                    n_state = cfa_pkg::S_HDEC;
                end
            end
            cfa_pkg::S_HDEC: begin
                if (i_stat.chosen_ok) begin
                    n_state = cfa_pkg::S_CARVE;
                end else begin
                    o_cmd.op   = cfa_pkg::OP_SETST;
                    o_cmd.code = cfa_pkg::ST_NO_FIT;
                    n_state    = cfa_pkg::S_LSCAN;
                end
            end
            cfa_pkg::S_CARVE: begin
                o_cmd.op = cfa_pkg::OP_CARVE;
                n_state  = cfa_pkg::S_LSCAN;
            end
            cfa_pkg::S_RTAKE: begin
                o_cmd.op = cfa_pkg::OP_RTAKE;
                n_state  = cfa_pkg::S_PSCAN;
            end
            cfa_pkg::S_PSCAN: begin
                o_cmd.op = cfa_pkg::OP_PSCAN;
                if (i_stat.h_last) begin
                    n_state = cfa_pkg::S_MERGE;
                end
            end
            cfa_pkg::S_MERGE: begin
                o_cmd.op = cfa_pkg::OP_MERGE;
                n_state  = cfa_pkg::S_LSCAN;
            end
            cfa_pkg::S_CPASS: begin
                o_cmd.op = cfa_pkg::OP_CPASS;
                if (i_stat.b_last) begin
                    n_state = cfa_pkg::S_CDEC;
                end
            end
            cfa_pkg::S_CDEC: begin
                n_state = i_stat.best_ok ? cfa_pkg::S_CPLACE : cfa_pkg::S_CFILL;
            end
            cfa_pkg::S_CPLACE: begin
                o_cmd.op = cfa_pkg::OP_CPLACE;
                n_state  = cfa_pkg::S_CPASS;
            end
            cfa_pkg::S_CFILL: begin
                o_cmd.op = cfa_pkg::OP_CFILL;
                n_state  = cfa_pkg::S_LSCAN;
            end
            cfa_pkg::S_LSCAN: begin
                o_cmd.op = cfa_pkg::OP_LSCAN;
                if (i_stat.h_last) begin
                    n_state = cfa_pkg::S_OUT;
                end
            end
            cfa_pkg::S_OUT: begin
                // Wait until the previous word has left the output register.
                if (!i_stat.out_busy) begin
                    o_cmd.op = cfa_pkg::OP_EMIT;
                    n_state  = cfa_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = cfa_pkg::S_IDLE;
            end
        endcase
    end

`ifndef NO_ASSERTIONS
    a_carve_after_fit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.op == cfa_pkg::OP_CARVE |-> $past(r_state) == cfa_pkg::S_HDEC)
        else $error("carve issued without a completed hole search");

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.op == cfa_pkg::OP_EMIT |-> !i_stat.out_busy)
        else $error("result emitted over a pending word");

    a_out_leaves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == cfa_pkg::S_OUT && !i_stat.out_busy) |=> r_state == cfa_pkg::S_IDLE)
        else $error("output state did not return to idle");
`endif

endmodule

/* src/contiguous_fit_allocator.sv */
// Contiguous memory allocator with first, best and worst fit over a block table of
// MAX_BLOCKS entries and an address-sorted hole table of MAX_BLOCKS+1 entries. One
// input word (request, release, compact or report) gives one result word. Work is
// done by a sequencer that walks the tables one entry per cycle: a request runs a
// block scan, a hole scan and a largest-hole scan, a release a block scan, a position
// scan and a largest-hole scan, a report a largest-hole scan, and a compaction a block
// pass per block placed plus one, then a largest-hole scan. A new input word is
// taken once the previous one is finished, even while its result still waits in the
// output register. Writing total_memory on the configuration port frees every block
// and leaves one hole over the whole memory (none if zero); it is taken only while idle.
module contiguous_fit_allocator #(
    parameter int MAX_BLOCKS = cfa_pkg::DEF_MAX_BLOCKS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  cfa_pkg::t_in_word              i_in_word,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output cfa_pkg::t_out_word             o_out_word,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [cfa_pkg::ADDR_BITS-1:0]  i_cfg_data
);

    cfa_pkg::t_cmd     cmd;
    cfa_pkg::t_dp_stat stat;

    cfa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_cfg_valid (i_cfg_valid),
        .i_stat      (stat),
        .o_cmd       (cmd),
        .o_in_stall  (o_in_stall),
        .o_cfg_ready (o_cfg_ready)
    );

    cfa_dp #(
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_in_word   (i_in_word),
        .i_cfg_data  (i_cfg_data),
        .i_out_stall (i_out_stall),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word)
    );

endmodule
